// ===== design/rie_pkg.sv =====
// Shared types, constants and opcode codes for the instruction execute block.
package rie_pkg;

  localparam int DATA_WORDS_DEF     = 4096;
  localparam int REGISTER_COUNT_DEF = 16;

  localparam int WORD_W = 32;
  localparam int INSN_W = 20;
  localparam int IMM_W  = 20;
  localparam int PC_W   = 12;
  localparam int REG_W  = 4;
  localparam int PADDR_W = 12;

  typedef enum logic [7:0] {
    OP_ADD  = 8'd0,
    OP_SUB  = 8'd1,
    OP_MUL  = 8'd2,
    OP_AND  = 8'd3,
    OP_OR   = 8'd4,
    OP_XOR  = 8'd5,
    OP_SLL  = 8'd6,
    OP_SRA  = 8'd7,
    OP_SRL  = 8'd8,
    OP_BEQ  = 8'd9,
    OP_BNE  = 8'd10,
    OP_BLT  = 8'd11,
    OP_BGT  = 8'd12,
    OP_BLE  = 8'd13,
    OP_BGE  = 8'd14,
    OP_JAL  = 8'd15,
    OP_LW   = 8'd16,
    OP_SW   = 8'd17,
    OP_HALT = 8'd21
  } op_t;

  localparam logic KIND_EXEC    = 1'b0;
  localparam logic KIND_PRELOAD = 1'b1;

  // Back end sequencer states.
  typedef enum logic [1:0] {ST_CLEAR, ST_READ, ST_EXEC} st_t;

  // Decoded word handed from front to back.
  typedef struct packed {
    logic                     kind;
    logic [7:0]               op;
    logic [REG_W-1:0]         rd;
    logic [REG_W-1:0]         rs;
    logic [REG_W-1:0]         rt;
    logic                     itype;
    logic [WORD_W-1:0]        imm;
    logic [PADDR_W-1:0]       paddr;
    logic [WORD_W-1:0]        pval;
  } dec_t;

  typedef struct packed {
    logic [PC_W-1:0]   next_pc;
    logic              write_valid;
    logic [REG_W-1:0]  write_register;
    logic [WORD_W-1:0] write_value;
    logic              halted;
    logic [1:0]        cycle_count;
  } res_t;

endpackage

// ===== design/rie_if.sv =====
// Valid/ready channel interfaces for the instruction execute block.
interface rie_in_if;
  import rie_pkg::*;
  logic                valid;
  logic                ready;
  logic                opcode;
  logic [INSN_W-1:0]   instruction_word;
  logic signed [IMM_W-1:0]  immediate;
  logic [PADDR_W-1:0]  preload_address;
  logic signed [WORD_W-1:0] preload_value;
  modport source (output valid, opcode, instruction_word, immediate, preload_address,
                  preload_value, input ready);
  modport sink (input valid, opcode, instruction_word, immediate, preload_address,
                preload_value, output ready);
endinterface

interface rie_out_if;
  import rie_pkg::*;
  logic                valid;
  logic                ready;
  logic [PC_W-1:0]     next_pc;
  logic                write_valid;
  logic [REG_W-1:0]    write_register;
  logic signed [WORD_W-1:0] write_value;
  logic                halted;
  logic [1:0]          cycle_count;
  modport source (output valid, next_pc, write_valid, write_register, write_value, halted,
                  cycle_count, input ready);
  modport sink (input valid, next_pc, write_valid, write_register, write_value, halted,
                cycle_count, output ready);
endinterface

// ===== design/rie_front.sv =====
// Front end: accept words, decode fields and sign-extend the immediate.
module rie_front (
  input  logic              clk,
  input  logic              rst_n,
  rie_in_if.sink            in_ch,
  output rie_pkg::dec_t     dec_o,
  output logic              dec_valid_o,
  input  logic              dec_ready_i
);
  import rie_pkg::*;

  dec_t dec_r, dec_nxt;
  logic vld_r;

  assign in_ch.ready  = !vld_r || dec_ready_i;
  assign dec_o        = dec_r;
  assign dec_valid_o  = vld_r;

  always_comb begin
    dec_nxt.kind  = in_ch.opcode;
    dec_nxt.op    = in_ch.instruction_word[19:12];
    dec_nxt.rd    = in_ch.instruction_word[11:8];
    dec_nxt.rs    = in_ch.instruction_word[7:4];
    dec_nxt.rt    = in_ch.instruction_word[3:0];
    dec_nxt.itype = (in_ch.instruction_word[11:8] == REG_W'(1)) ||
                    (in_ch.instruction_word[7:4] == REG_W'(1)) ||
                    (in_ch.instruction_word[3:0] == REG_W'(1));
    dec_nxt.imm   = WORD_W'(in_ch.immediate);
    dec_nxt.paddr = in_ch.preload_address;
    dec_nxt.pval  = in_ch.preload_value;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      vld_r <= in_ch.valid;
    end
    if (in_ch.ready && in_ch.valid) begin
      dec_r <= dec_nxt;
    end
  end
endmodule

// ===== design/rie_fifo.sv =====
// Two-entry queue of decoded words between front and back.
module rie_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  rie_pkg::dec_t wr_data,
  input  logic          wr_valid,
  output logic          wr_ready,
  output rie_pkg::dec_t rd_data,
  output logic          rd_valid,
  input  logic          rd_ready
);
  import rie_pkg::*;

  dec_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop)  rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
    if (push) mem_r[wp_r] <= wr_data;
  end
endmodule

// ===== design/rie_back.sv =====
// Back end: register file, data memory and the execute sequencer (operand read, then execute).
module rie_back #(
  parameter int DATA_WORDS = rie_pkg::DATA_WORDS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  rie_pkg::dec_t dec_i,
  input  logic          dec_valid_i,
  output logic          dec_ready_o,
  rie_out_if.source     out_ch
);
  import rie_pkg::*;
  localparam int AW = $clog2(DATA_WORDS);

  st_t  st_r, st_nxt;
  logic [AW:0] clr_r;
  logic [WORD_W-1:0] regs_r [REGISTER_COUNT_DEF];
  logic [WORD_W-1:0] dmem [DATA_WORDS];
  logic [WORD_W-1:0] rdat_r;
  logic [PC_W-1:0]   pc_r;
  logic              halt_r;
  dec_t              d_r;
  logic [WORD_W-1:0] a_r, b_r, c_r;
  logic [WORD_W-1:0] a_in, b_in, c_in;
  res_t              res_r, res_nxt;
  logic              ovld_r;
  logic              out_free;

  // operand read: register zero reads as zero, register one is taken from the immediate
  function automatic logic [WORD_W-1:0] rd_reg(input dec_t d, input logic [REG_W-1:0] i,
                                               input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] r;
    r = v;
    if (i == REG_W'(0)) r = '0;
    else if (i == REG_W'(1) && d.itype) r = d.imm;
    return r;
  endfunction

  assign out_free    = !ovld_r || out_ch.ready;
  assign dec_ready_o = (st_r == ST_READ);

  assign a_in = rd_reg(dec_i, dec_i.rs, regs_r[dec_i.rs]);
  assign b_in = rd_reg(dec_i, dec_i.rt, regs_r[dec_i.rt]);
  assign c_in = rd_reg(dec_i, dec_i.rd, regs_r[dec_i.rd]);

  logic [WORD_W-1:0] a, b, res;
  logic [PC_W-1:0]   seqpc, nxt_pc;
  logic              wr, take, mwr, dohalt, exec;
  logic [AW-1:0]     maddr;
  logic [63:0]       prod;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_CLEAR: if (clr_r == (AW+1)'(DATA_WORDS-1)) st_nxt = ST_READ;
      ST_READ:  if (dec_valid_i) st_nxt = ST_EXEC;
      ST_EXEC:  if (out_free) st_nxt = ST_READ;
      default:  st_nxt = ST_READ;
    endcase
  end

  always_comb begin
    a = a_r; b = b_r;
    exec  = (d_r.kind == KIND_EXEC) && !halt_r;
    seqpc = pc_r + (d_r.itype ? PC_W'(2) : PC_W'(1));
    nxt_pc = pc_r; res = '0; wr = 1'b0; take = 1'b0; mwr = 1'b0; dohalt = 1'b0;
    maddr = AW'(a + b);
    prod  = {32'd0, a} * {32'd0, b};
    if (exec) begin
      nxt_pc = seqpc;
      case (d_r.op)
        OP_ADD: begin res = a + b; wr = 1'b1; end
        OP_SUB: begin res = a - b; wr = 1'b1; end
        OP_MUL: begin res = prod[31:0]; wr = 1'b1; end
        OP_AND: begin res = a & b; wr = 1'b1; end
        OP_OR:  begin res = a | b; wr = 1'b1; end
        OP_XOR: begin res = a ^ b; wr = 1'b1; end
        OP_SLL: begin res = a << b[4:0]; wr = 1'b1; end
        OP_SRA: begin res = WORD_W'($signed(a) >>> b[4:0]); wr = 1'b1; end
        OP_SRL: begin res = a >> b[4:0]; wr = 1'b1; end
        OP_BEQ: take = (a == b);
        OP_BNE: take = (a != b);
        OP_BLT: take = ($signed(a) < $signed(b));
        OP_BGT: take = ($signed(a) > $signed(b));
        OP_BLE: take = ($signed(a) <= $signed(b));
        OP_BGE: take = ($signed(a) >= $signed(b));
        OP_JAL: begin res = WORD_W'(seqpc); wr = 1'b1; nxt_pc = a[PC_W-1:0]; end
        OP_LW:  begin res = rdat_r; wr = 1'b1; end
        OP_SW:  mwr = 1'b1;
        OP_HALT: dohalt = 1'b1;
        default: ;
      endcase
      if (take) nxt_pc = c_r[PC_W-1:0];
    end
    wr = wr && (d_r.rd != REG_W'(0));
    res_nxt.next_pc        = nxt_pc;
    res_nxt.write_valid    = wr;
    res_nxt.write_register = wr ? d_r.rd : '0;
    res_nxt.write_value    = wr ? res : '0;
    res_nxt.halted         = halt_r || dohalt;
    res_nxt.cycle_count    = !exec ? 2'd0 :
      (((d_r.op == OP_LW) || (d_r.op == OP_SW)) && d_r.itype) ? 2'd3 :
      (d_r.itype ? 2'd2 : 2'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_CLEAR;
      clr_r  <= '0;
      pc_r   <= '0;
      halt_r <= 1'b0;
      ovld_r <= 1'b0;
      for (int i = 0; i < REGISTER_COUNT_DEF; i++) regs_r[i] <= '0;
    end else begin
      st_r <= st_nxt;
      if (st_r == ST_EXEC && out_free) ovld_r <= 1'b1;
      else if (out_ch.ready) ovld_r <= 1'b0;
      if (st_r == ST_CLEAR) clr_r <= clr_r + 1'b1;
      if (st_r == ST_READ && dec_valid_i) begin
        d_r <= dec_i;
        a_r <= a_in;
        b_r <= b_in;
        c_r <= c_in;
      end
      if (st_r == ST_EXEC && out_free) begin
        res_r  <= res_nxt;
        pc_r   <= res_nxt.next_pc;
        halt_r <= res_nxt.halted;
        // the write-back to register one wins over the immediate
        if (exec && d_r.itype && !(wr && d_r.rd == REG_W'(1))) regs_r[1] <= d_r.imm;
        if (wr) regs_r[d_r.rd] <= res;
      end
    end
  end

  // data memory: one write port, one registered read port addressed at operand read
  always_ff @(posedge clk) begin
    if (st_r == ST_READ) rdat_r <= dmem[AW'(a_in + b_in)];
    if (st_r == ST_CLEAR) dmem[clr_r[AW-1:0]] <= '0;
    else if (st_r == ST_EXEC && out_free) begin
      if (d_r.kind == KIND_PRELOAD) dmem[AW'(d_r.paddr)] <= d_r.pval;
      else if (mwr) dmem[maddr] <= c_r;
    end
  end

  assign out_ch.valid          = ovld_r;
  assign out_ch.next_pc        = res_r.next_pc;
  assign out_ch.write_valid    = res_r.write_valid;
  assign out_ch.write_register = res_r.write_register;
  assign out_ch.write_value    = res_r.write_value;
  assign out_ch.halted         = res_r.halted;
  assign out_ch.cycle_count    = res_r.cycle_count;
endmodule

// ===== design/risc_instruction_execute_top.sv =====
// Top level of the instruction execute block.
// Use: drive words on the in_ channel (valid/ready). A word with opcode 0
// executes one instruction against the internal register file, program
// counter and data memory; opcode 1 stores preload_value at preload_address.
// Every accepted word yields exactly one word on the out_ channel: next pc,
// register write-back, halt flag and cycle count.
// A word passes the front register and the queue, then operand read and
// execute in the back end.
// The back end sequencer reads operands and the data memory port in its read
// state and executes and writes back in its execute state, so it takes a new
// word only once it is through with the last.
// Reset: synchronous, active low. The back end then sweeps the data memory to
// zero, one word a cycle, while the queue fills and then holds; in_ready drops
// once the front stage and queue are full.
// When the receiver stalls, the result holds in the output register and the
// back end waits; the queue and front stage keep taking words until full.
module risc_instruction_execute_top #(
  parameter int DATA_WORDS = rie_pkg::DATA_WORDS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  rie_in_if.sink    in_ch,
  rie_out_if.source out_ch
);
  import rie_pkg::*;

  dec_t f_dec, q_dec;
  logic f_vld, f_rdy, q_vld, q_rdy;

  rie_front u_front (
    .clk, .rst_n, .in_ch(in_ch),
    .dec_o(f_dec), .dec_valid_o(f_vld), .dec_ready_i(f_rdy)
  );

  rie_fifo u_fifo (
    .clk, .rst_n,
    .wr_data(f_dec), .wr_valid(f_vld), .wr_ready(f_rdy),
    .rd_data(q_dec), .rd_valid(q_vld), .rd_ready(q_rdy)
  );

  rie_back #(.DATA_WORDS(DATA_WORDS)) u_back (
    .clk, .rst_n,
    .dec_i(q_dec), .dec_valid_i(q_vld), .dec_ready_o(q_rdy),
    .out_ch(out_ch)
  );
endmodule

// ===== tb/rie_tb_pkg.sv =====
// Stimulus and expected-result types shared by the instruction execute testbench.
package rie_tb_pkg;
  import rie_pkg::*;

  typedef struct {
    logic                     kind;
    logic [INSN_W-1:0]        insn;
    logic signed [IMM_W-1:0]  imm;
    logic [PADDR_W-1:0]       paddr;
    logic signed [WORD_W-1:0] pval;
  } insn_word_t;

  typedef struct {
    logic [PC_W-1:0]   next_pc;
    logic              write_valid;
    logic [REG_W-1:0]  write_register;
    logic [WORD_W-1:0] write_value;
    logic              halted;
    logic [1:0]        cycle_count;
  } exec_res_t;

  function automatic logic [INSN_W-1:0] pack_insn(op_t op, logic [3:0] rd, logic [3:0] rs,
                                                  logic [3:0] rt);
    return {8'(op), rd, rs, rt};
  endfunction
endpackage

// ===== tb/risc_instruction_execute_top_tb.sv =====
// Self-checking testbench for the instruction execute block: directed table, then random.
module risc_instruction_execute_top_tb;
  import rie_pkg::*;
  import rie_tb_pkg::*;

  localparam int RUN_ITEMS = 1900;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  rie_in_if  in_ch ();
  rie_out_if out_ch ();

  risc_instruction_execute_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow architectural state, updated as each word is accepted.
  logic [WORD_W-1:0] shadow_regs [16];
  logic [WORD_W-1:0] shadow_mem [DATA_WORDS_DEF];
  logic [PC_W-1:0]   shadow_pc;
  logic              shadow_halt;

  exec_res_t expected_results[$];
  // Typed-in expectations for directed rows, checked against the shadow too.
  exec_res_t typed_results[$];
  bit        typed_valid[$];

  int errors = 0;
  int words_sent = 0;
  int words_seen = 0;
  int writes_seen = 0;
  bit drain_phase = 1'b0;

  function automatic logic [WORD_W-1:0] reg_read(logic [3:0] idx);
    return (idx == 4'd0) ? '0 : shadow_regs[idx];
  endfunction

  // Report every field where a typed-in row and the predictor disagree.
  function automatic int typed_mismatches(exec_res_t t, exec_res_t e);
    int n;
    n = 0;
    if (t.next_pc !== e.next_pc) begin
      $error("typed next_pc exp %0d got %0d", t.next_pc, e.next_pc); n++;
    end
    if (t.write_valid !== e.write_valid) begin
      $error("typed write_valid exp %0d got %0d", t.write_valid, e.write_valid); n++;
    end
    if (t.write_register !== e.write_register) begin
      $error("typed write_register exp %0d got %0d", t.write_register, e.write_register); n++;
    end
    if (t.write_value !== e.write_value) begin
      $error("typed write_value exp %h got %h", t.write_value, e.write_value); n++;
    end
    if (t.halted !== e.halted) begin
      $error("typed halted exp %0d got %0d", t.halted, e.halted); n++;
    end
    if (t.cycle_count !== e.cycle_count) begin
      $error("typed cycle_count exp %0d got %0d", t.cycle_count, e.cycle_count); n++;
    end
    return n;
  endfunction

  // Compute the result of one word and advance the shadow state.
  function automatic exec_res_t execute_word(insn_word_t w);
    exec_res_t r;
    logic [7:0] op;
    logic [3:0] rd, rs, rt;
    logic itype, wr, take;
    logic [WORD_W-1:0] a, b, res;
    logic [PC_W-1:0] nxt;
    logic [11:0] addr;
    r = '{default: '0};
    r.next_pc = shadow_pc;
    if (w.kind == KIND_PRELOAD) begin
      shadow_mem[w.paddr] = w.pval;
    end else if (!shadow_halt) begin
      op = w.insn[19:12];
      rd = w.insn[11:8];
      rs = w.insn[7:4];
      rt = w.insn[3:0];
      itype = (rd == 4'd1) || (rs == 4'd1) || (rt == 4'd1);
      if (itype) shadow_regs[1] = {{12{w.imm[19]}}, w.imm};
      r.cycle_count = itype ? 2'd2 : 2'd1;
      nxt = shadow_pc + (itype ? 12'd2 : 12'd1);
      a = reg_read(rs);
      b = reg_read(rt);
      wr = 1'b0;
      res = '0;
      take = 1'b0;
      case (op)
        OP_ADD: res = a + b;
        OP_SUB: res = a - b;
        OP_MUL: res = a * b;
        OP_AND: res = a & b;
        OP_OR:  res = a | b;
        OP_XOR: res = a ^ b;
        OP_SLL: res = a << b[4:0];
        OP_SRA: res = $signed(a) >>> b[4:0];
        OP_SRL: res = a >> b[4:0];
        OP_BEQ: take = (a == b);
        OP_BNE: take = (a != b);
        OP_BLT: take = ($signed(a) < $signed(b));
        OP_BGT: take = ($signed(a) > $signed(b));
        OP_BLE: take = ($signed(a) <= $signed(b));
        OP_BGE: take = ($signed(a) >= $signed(b));
        OP_JAL: begin
          res = {20'd0, nxt};
          nxt = a[11:0];
        end
        OP_LW, OP_SW: begin
          addr = a[11:0] + b[11:0];
          if (itype) r.cycle_count = 2'd3;
          if (op == OP_LW) res = shadow_mem[addr];
          else shadow_mem[addr] = reg_read(rd);
        end
        OP_HALT: shadow_halt = 1'b1;
        default: ;
      endcase
      wr = (op <= OP_SRL) || (op == OP_JAL) || (op == OP_LW);
      if (take) nxt = reg_read(rd) & 12'hFFF;
      if (wr && rd != 4'd0) begin
        shadow_regs[rd] = res;
        r.write_valid = 1'b1;
        r.write_register = rd;
        r.write_value = res;
      end
      shadow_pc = nxt;
      r.next_pc = nxt;
    end
    r.halted = shadow_halt;
    return r;
  endfunction

  // Directed table: each row a word, with an optional typed-in result.
  typedef struct {
    insn_word_t w;
    bit         has_typed;
    exec_res_t  typed;
  } dir_row_t;
  dir_row_t dir_rows[$];

  task automatic add_row(logic kind, logic [INSN_W-1:0] insn, logic signed [IMM_W-1:0] imm,
                         logic [PADDR_W-1:0] pa, logic signed [WORD_W-1:0] pv,
                         bit has_typed = 1'b0, exec_res_t t = '{default: '0});
    dir_row_t row;
    row.w = '{kind, insn, imm, pa, pv};
    row.has_typed = has_typed;
    row.typed = t;
    dir_rows.push_back(row);
  endtask

  task automatic send_word(insn_word_t w, bit idle_ok);
    exec_res_t r;
    if (idle_ok && !drain_phase && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.opcode <= w.kind;
    in_ch.instruction_word <= w.insn;
    in_ch.immediate <= w.imm;
    in_ch.preload_address <= w.paddr;
    in_ch.preload_value <= w.pval;
    do @(posedge clk); while (!in_ch.ready);
    r = execute_word(w);
    expected_results.push_back(r);
    words_sent++;
  endtask

  function automatic logic [3:0] pick_reg();
    // favor the immediate register and a few others so values flow between ops
    case ($urandom_range(0, 3))
      0: return 4'd1;
      1: return 4'($urandom_range(0, 3));
      default: return 4'($urandom_range(0, 15));
    endcase
  endfunction

  function automatic insn_word_t random_word();
    insn_word_t w;
    logic [7:0] op;
    int sel;
    w.kind = ($urandom_range(0, 9) == 0) ? KIND_PRELOAD : KIND_EXEC;
    sel = $urandom_range(0, 99);
    if (sel < 90) op = 8'($urandom_range(0, 17));
    else if (sel < 99) op = 8'($urandom_range(18, 255));
    else op = OP_HALT;
    if (op == OP_HALT && $urandom_range(0, 2) != 0) op = OP_ADD;
    w.insn = {op, pick_reg(), pick_reg(), pick_reg()};
    if ($urandom_range(0, 3) == 0) w.insn[11:0] = 12'($urandom);
    case ($urandom_range(0, 3))
      0: w.imm = 20'($urandom_range(0, 40));
      1: w.imm = -20'sd1 - 20'($urandom_range(0, 40));
      default: w.imm = 20'($urandom);
    endcase
    // keep most preloads low so loads hit them
    w.paddr = ($urandom_range(0, 1) == 0) ? 12'($urandom_range(0, 63)) : 12'($urandom);
    w.pval = $urandom;
    return w;
  endfunction

  // Result side: random stalls on ready, compare against oldest expectation.
  initial begin
    out_ch.ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (!drain_phase && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        exec_res_t e;
        words_seen++;
        if (expected_results.size() == 0) begin
          $error("result word with nothing expected");
          errors++;
        end else begin
          e = expected_results.pop_front();
          if (typed_valid.size() != 0) begin
            exec_res_t t;
            t = typed_results.pop_front();
            if (typed_valid.pop_front()) errors += typed_mismatches(t, e);
          end
          if (out_ch.write_valid) writes_seen++;
          if (out_ch.next_pc !== e.next_pc) begin
            $error("next_pc exp %0d got %0d", e.next_pc, out_ch.next_pc); errors++;
          end
          if (out_ch.write_valid !== e.write_valid) begin
            $error("write_valid exp %0d got %0d", e.write_valid, out_ch.write_valid); errors++;
          end
          if (out_ch.write_register !== e.write_register) begin
            $error("write_register exp %0d got %0d", e.write_register, out_ch.write_register);
            errors++;
          end
          if (out_ch.write_value !== e.write_value) begin
            $error("write_value exp %h got %h", e.write_value, out_ch.write_value); errors++;
          end
          if (out_ch.halted !== e.halted) begin
            $error("halted exp %0d got %0d", e.halted, out_ch.halted); errors++;
          end
          if (out_ch.cycle_count !== e.cycle_count) begin
            $error("cycle_count exp %0d got %0d", e.cycle_count, out_ch.cycle_count); errors++;
          end
        end
      end
    end
  end

  // Source side: reset, directed table, random words, then drain and report.
  initial begin
    exec_res_t t;
    insn_word_t w;
    int wait_cycles;
    in_ch.valid = 1'b0;
    in_ch.opcode = KIND_EXEC;
    in_ch.instruction_word = '0;
    in_ch.immediate = '0;
    in_ch.preload_address = '0;
    in_ch.preload_value = '0;
    foreach (shadow_regs[i]) shadow_regs[i] = '0;
    foreach (shadow_mem[i]) shadow_mem[i] = '0;
    shadow_pc = '0;
    shadow_halt = 1'b0;

    // add r0,r0,r0 after reset: pc 1, no write
    t = '{next_pc: 12'd1, write_valid: 1'b0, write_register: 4'd0, write_value: '0,
          halted: 1'b0, cycle_count: 2'd1};
    add_row(KIND_EXEC, pack_insn(OP_ADD, 4'd0, 4'd0, 4'd0), '0, '0, '0, 1'b1, t);
    // r2 = r1 + r0 with the largest positive immediate
    t = '{next_pc: 12'd3, write_valid: 1'b1, write_register: 4'd2, write_value: 32'h0007FFFF,
          halted: 1'b0, cycle_count: 2'd2};
    add_row(KIND_EXEC, pack_insn(OP_ADD, 4'd2, 4'd1, 4'd0), 20'sh7FFFF, '0, '0, 1'b1, t);
    // r3 = most negative immediate, sign-extended
    t = '{next_pc: 12'd5, write_valid: 1'b1, write_register: 4'd3, write_value: 32'hFFF80000,
          halted: 1'b0, cycle_count: 2'd2};
    add_row(KIND_EXEC, pack_insn(OP_OR, 4'd3, 4'd1, 4'd0), -20'sh80000, '0, '0, 1'b1, t);
    add_row(KIND_EXEC, pack_insn(OP_SUB, 4'd4, 4'd2, 4'd3), '0, '0, '0);
    add_row(KIND_EXEC, pack_insn(OP_MUL, 4'd5, 4'd3, 4'd3), '0, '0, '0);
    add_row(KIND_EXEC, pack_insn(OP_AND, 4'd6, 4'd2, 4'd3), '0, '0, '0);
    add_row(KIND_EXEC, pack_insn(OP_XOR, 4'd7, 4'd2, 4'd3), '0, '0, '0);
    // shifts by 31 and by 33 (modulo 32)
    add_row(KIND_EXEC, pack_insn(OP_SLL, 4'd8, 4'd2, 4'd1), 20'sd31, '0, '0);
    add_row(KIND_EXEC, pack_insn(OP_SRA, 4'd9, 4'd3, 4'd1), 20'sd33, '0, '0);
    add_row(KIND_EXEC, pack_insn(OP_SRL, 4'd10, 4'd3, 4'd1), 20'sd31, '0, '0);
    // writes to r0 are dropped
    add_row(KIND_EXEC, pack_insn(OP_ADD, 4'd0, 4'd2, 4'd2), '0, '0, '0);
    // rd is the immediate register: result replaces the immediate
    add_row(KIND_EXEC, pack_insn(OP_ADD, 4'd1, 4'd1, 4'd1), 20'sd5, '0, '0);
    add_row(KIND_PRELOAD, '0, '0, 12'hFFF, 32'sh80000000);
    add_row(KIND_PRELOAD, '0, '0, 12'd0, 32'sh7FFFFFFF);
    // loads: address wraps past the top of memory
    add_row(KIND_EXEC, pack_insn(OP_LW, 4'd11, 4'd1, 4'd0), -20'sd1, '0, '0);
    add_row(KIND_EXEC, pack_insn(OP_LW, 4'd12, 4'd0, 4'd0), '0, '0, '0);
    add_row(KIND_EXEC, pack_insn(OP_SW, 4'd3, 4'd1, 4'd0), 20'sd7, '0, '0);
    add_row(KIND_EXEC, pack_insn(OP_LW, 4'd13, 4'd1, 4'd0), 20'sd7, '0, '0);
    // branches: target from rd, taken and untaken
    add_row(KIND_EXEC, pack_insn(OP_BEQ, 4'd1, 4'd0, 4'd0), 20'sd100, '0, '0);
    add_row(KIND_EXEC, pack_insn(OP_BNE, 4'd2, 4'd0, 4'd0), '0, '0, '0);
    add_row(KIND_EXEC, pack_insn(OP_BLT, 4'd2, 4'd3, 4'd2), '0, '0, '0);
    add_row(KIND_EXEC, pack_insn(OP_BGT, 4'd2, 4'd3, 4'd2), '0, '0, '0);
    add_row(KIND_EXEC, pack_insn(OP_BLE, 4'd3, 4'd2, 4'd2), '0, '0, '0);
    add_row(KIND_EXEC, pack_insn(OP_BGE, 4'd2, 4'd2, 4'd3), '0, '0, '0);
    add_row(KIND_EXEC, pack_insn(OP_JAL, 4'd14, 4'd1, 4'd0), 20'sd40, '0, '0);
    add_row(KIND_EXEC, {8'd200, 12'h234}, '0, '0, '0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      typed_results.push_back(dir_rows[i].typed);
      typed_valid.push_back(dir_rows[i].has_typed);
      send_word(dir_rows[i].w, 1'b1);
    end

    // Random part; halt sequences end a program, so reset shadow cannot restart -
    // after a halt most words are ignored, hence halt is kept out of all but the last 20 words.
    for (int n = 0; n < RUN_ITEMS; n++) begin
      if (n == RUN_ITEMS - 200) drain_phase = 1'b1;
      w = random_word();
      if (n < RUN_ITEMS - 20 && w.kind == KIND_EXEC && w.insn[19:12] == OP_HALT)
        w.insn[19:12] = OP_XOR;
      if (n == RUN_ITEMS - 10) w = '{KIND_EXEC, pack_insn(OP_HALT, 4'd0, 4'd0, 4'd0), '0, '0, '0};
      send_word(w, 1'b1);
    end
    in_ch.valid <= 1'b0;

    wait_cycles = 0;
    while (expected_results.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (10) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      errors++;
    end
    $display("Sent %0d words (directed table plus random programs with preloads and halt);",
             words_sent);
    $display("checked %0d results, %0d with a register write.", words_seen, writes_seen);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog: covers the post-reset memory sweep and worst-case stalls.
  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end
endmodule

// ===== risc_instruction_execute_top.f =====
design/rie_pkg.sv
design/rie_if.sv
design/rie_front.sv
design/rie_fifo.sv
design/rie_back.sv
design/risc_instruction_execute_top.sv
tb/rie_tb_pkg.sv
tb/risc_instruction_execute_top_tb.sv
